// ===== design/pgm_hdr_pkg.sv =====
// Shared types and constants for the binary greyscale image header parser.
// No dependencies; compiled first.
package pgm_hdr_pkg;

    localparam int BYTE_W = 8;
    localparam int DIM_W  = 16;
    localparam int ACC_W  = 17;
    localparam int PIX_W  = 32;

    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
    localparam logic [BYTE_W-1:0] CH_P    = 8'h50;
    localparam logic [BYTE_W-1:0] CH_5    = 8'h35;
    localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9    = 8'h39;

    localparam logic [ACC_W-1:0] ACC_SAT  = 17'd65536;
    localparam logic [ACC_W-1:0] ACC_MAX  = 17'd65535;
    localparam logic [ACC_W-1:0] GREY_MAX = 17'd255;

    typedef enum logic [2:0] {
        ST_HEADER     = 3'd0,
        ST_PIXEL      = 3'd1,
        ST_LAST_PIXEL = 3'd2,
        ST_ERROR      = 3'd3,
        ST_TRAILING   = 3'd4
    } status_t;

    typedef enum logic [7:0] {
        PH_MAGIC   = 8'b0000_0001,
        PH_WIDTH   = 8'b0000_0010,
        PH_HEIGHT  = 8'b0000_0100,
        PH_GREY    = 8'b0000_1000,
        PH_HDRDONE = 8'b0001_0000,
        PH_PIXELS  = 8'b0010_0000,
        PH_DONE    = 8'b0100_0000,
        PH_ERROR   = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        LM_START = 3'b001,
        LM_LINE  = 3'b010,
        LM_SKIP  = 3'b100
    } line_mode_t;

    typedef struct packed {
        status_t           status;
        logic [BYTE_W-1:0] pixel;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
    } result_t;

endpackage

// ===== design/pgm_hdr_if.sv =====
// Valid/ready channel interfaces for file bytes in and result words out.
// Depends on pgm_hdr_pkg.
interface pgm_byte_if;
    logic                          valid;
    logic                          ready;
    logic [pgm_hdr_pkg::BYTE_W-1:0] data_byte;
    logic                          last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface pgm_result_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [pgm_hdr_pkg::BYTE_W-1:0] pixel;
    logic [pgm_hdr_pkg::DIM_W-1:0]  image_width;
    logic [pgm_hdr_pkg::DIM_W-1:0]  image_height;

    modport source (output valid, status, pixel, image_width, image_height, input ready);
    modport sink   (input valid, status, pixel, image_width, image_height, output ready);
endinterface

// ===== design/pgm_hdr_fsm.sv =====
// Parser state registers and per-byte next-state logic; builds one result word per byte.
// Depends on pgm_hdr_pkg.
module pgm_hdr_fsm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [pgm_hdr_pkg::BYTE_W-1:0] data_byte,
    input  logic                           last_byte,
    output pgm_hdr_pkg::result_t           result
);
    import pgm_hdr_pkg::*;

    phase_t            phase_reg, phase_next;
    line_mode_t        lm_reg, lm_next;
    logic              fs_reg, fs_next;
    logic              fil_reg, fil_next;
    logic              mp_reg, mp_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic [PIX_W-1:0]  left_reg, left_next;
    logic [PIX_W-1:0]  prod_reg;

    logic              is_lf, is_digit, is_blank, is_hash;
    logic              skip, fin;
    logic [ACC_W-1:0]  fval;
    logic [20:0]       acc_mul;
    status_t           st;
    logic [BYTE_W-1:0] pix;

    assign is_lf    = (data_byte == CH_LF);
    assign is_hash  = (data_byte == CH_HASH);
    assign is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
    assign is_blank = data_byte inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    assign acc_mul  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {17'd0, data_byte[3:0]};

    always_comb
    begin
        phase_next  = phase_reg;
        lm_next     = lm_reg;
        fs_next     = fs_reg;
        fil_next    = fil_reg;
        mp_next     = mp_reg;
        acc_next    = acc_reg;
        width_next  = width_reg;
        height_next = height_reg;
        left_next   = left_reg;
        st          = ST_HEADER;
        pix         = '0;
        skip        = 1'b0;
        fin         = 1'b0;
        fval        = acc_reg;

        case (phase_reg)
            PH_ERROR:
            begin
                st = ST_ERROR;
            end
            PH_DONE:
            begin
                st = ST_TRAILING;
            end
            PH_PIXELS:
            begin
                pix = data_byte;
                if (left_reg <= 32'd1)
                begin
                    left_next  = '0;
                    phase_next = PH_DONE;
                    st         = ST_LAST_PIXEL;
                end
                else
                begin
                    left_next = left_reg - 32'd1;
                    st        = ST_PIXEL;
                end
            end
            PH_HDRDONE:
            begin
                if (is_lf)
                begin
                    left_next  = prod_reg;
                    phase_next = (prod_reg != '0) ? PH_PIXELS : PH_DONE;
                    lm_next    = LM_START;
                end
            end
            default:
            begin
                if (lm_reg == LM_START)
                begin
                    if (is_lf)
                        skip = 1'b1;
                    else if (is_hash)
                    begin
                        lm_next = LM_SKIP;
                        skip    = 1'b1;
                    end
                    else
                    begin
                        lm_next  = LM_LINE;
                        fil_next = 1'b0;
                        mp_next  = 1'b0;
                        fs_next  = 1'b0;
                        acc_next = '0;
                    end
                end
                if (!skip && lm_reg == LM_SKIP)
                begin
                    if (is_lf)
                        lm_next = LM_START;
                    skip = 1'b1;
                end
                if (!skip)
                begin
                    if (phase_reg == PH_MAGIC)
                    begin
                        if (is_lf)
                            phase_next = PH_ERROR;
                        else if (!mp_next)
                        begin
                            if (data_byte == CH_P)
                                mp_next = 1'b1;
                            else if (!is_blank)
                                phase_next = PH_ERROR;
                        end
                        else if (data_byte == CH_5)
                        begin
                            phase_next = PH_WIDTH;
                            lm_next    = LM_SKIP;
                        end
                        else
                            phase_next = PH_ERROR;
                    end
                    else
                    begin
                        if (is_digit)
                        begin
                            if (!fs_next)
                            begin
                                acc_next = {13'd0, data_byte[3:0]};
                                fs_next  = 1'b1;
                            end
                            else if (acc_mul > {4'd0, ACC_SAT})
                                acc_next = ACC_SAT;
                            else
                                acc_next = acc_mul[ACC_W-1:0];
                        end
                        else
                            fin = fs_next;

                        // close the number in progress
                        if (fin)
                        begin
                            fval     = acc_next;
                            acc_next = '0;
                            fs_next  = 1'b0;
                            fil_next = 1'b1;
                            if (fval > ACC_MAX)
                                phase_next = PH_ERROR;
                            else if (phase_reg == PH_WIDTH)
                            begin
                                width_next = fval[DIM_W-1:0];
                                phase_next = PH_HEIGHT;
                            end
                            else if (phase_reg == PH_HEIGHT)
                            begin
                                height_next = fval[DIM_W-1:0];
                                phase_next  = PH_GREY;
                            end
                            else if (fval != GREY_MAX)
                                phase_next = PH_ERROR;
                            else
                            begin
                                phase_next = PH_HDRDONE;
                                lm_next    = LM_SKIP;
                            end
                        end

                        if (is_lf)
                        begin
                            if (phase_next == PH_HDRDONE)
                            begin
                                left_next  = prod_reg;
                                phase_next = (prod_reg != '0) ? PH_PIXELS : PH_DONE;
                                lm_next    = LM_START;
                            end
                            else if (phase_next != PH_ERROR)
                            begin
                                if (!fil_next)
                                    phase_next = PH_ERROR;
                                else
                                begin
                                    lm_next = LM_START;
                                    fs_next = 1'b0;
                                end
                            end
                        end
                        else if (!is_digit && !is_blank)
                        begin
                            if (fin)
                            begin
                                if (phase_next != PH_ERROR)
                                    lm_next = LM_SKIP;
                            end
                            else if (!fil_next)
                                phase_next = PH_ERROR;
                            else
                                lm_next = LM_SKIP;
                        end
                    end
                end
            end
        endcase

        if (phase_next != PH_ERROR && phase_next != PH_DONE && last_byte)
            phase_next = PH_ERROR;
        if (phase_next == PH_ERROR)
        begin
            st  = ST_ERROR;
            pix = '0;
        end
    end

    assign result.status       = st;
    assign result.pixel        = pix;
    assign result.image_width  = width_next;
    assign result.image_height = height_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            lm_reg     <= LM_START;
            fs_reg     <= 1'b0;
            fil_reg    <= 1'b0;
            mp_reg     <= 1'b0;
            acc_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            left_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            lm_reg     <= lm_next;
            fs_reg     <= fs_next;
            fil_reg    <= fil_next;
            mp_reg     <= mp_next;
            acc_reg    <= acc_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            left_reg   <= left_next;
        end
    end

    // height is fixed at least two words before the header newline
    always_ff @(posedge clk)
    begin
        prod_reg <= PIX_W'(width_reg) * PIX_W'(height_reg);
    end

    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PIXELS |-> left_reg != '0)
        else $error("pixel count empty while streaming pixels");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |=> phase_reg == PH_ERROR)
        else $error("error phase left");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> phase_reg == PH_ERROR || phase_reg == PH_DONE)
        else $error("final byte did not end the stream");

    a_dims_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_PIXELS |=> $stable(width_reg) && $stable(height_reg))
        else $error("dimensions changed during pixels");

endmodule

// ===== design/pgm_hdr_outreg.sv =====
// Output register stage: holds one result word until the sink takes it.
// Depends on pgm_hdr_pkg and pgm_result_if.
module pgm_hdr_outreg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  pgm_hdr_pkg::result_t result,
    output logic                 can_take,
    pgm_result_if.source         results
);
    import pgm_hdr_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign can_take = !valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (results.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign results.valid        = valid_reg;
    assign results.status       = data_reg.status;
    assign results.pixel        = data_reg.pixel;
    assign results.image_width  = data_reg.image_width;
    assign results.image_height = data_reg.image_height;

endmodule

// ===== design/pgm_binary_header_parser.sv =====
// Binary greyscale image header parser, top level.
// Each result word is registered and valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless a word is held; a word loads as the old one leaves.
// Reset (rst_n, async, low): parser back to awaiting the magic line, output empty.
// Depends on pgm_hdr_pkg, pgm_hdr_if, pgm_hdr_fsm, pgm_hdr_outreg.
module pgm_binary_header_parser (
    input  logic         clk,
    input  logic         rst_n,
    pgm_byte_if.sink     bytes,
    pgm_result_if.source results
);
    import pgm_hdr_pkg::*;

    logic    can_take;
    logic    accept;
    result_t result;

    assign bytes.ready = can_take;
    assign accept      = bytes.valid && can_take;

    pgm_hdr_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (bytes.data_byte),
        .last_byte (bytes.last_byte),
        .result    (result)
    );

    pgm_hdr_outreg u_outreg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .result   (result),
        .can_take (can_take),
        .results  (results)
    );

endmodule

// ===== verif/pgm_binary_header_parser_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pgm_binary_header_parser: streams one image file, checks each word.
// Depends on pgm_hdr_pkg, pgm_hdr_if and the parser RTL.
module pgm_binary_header_parser_test;
    import pgm_hdr_pkg::*;

    localparam int ITEM_TOTAL = 1100;

    localparam result_t HEADER_QUIET = '{
        status: ST_HEADER, pixel: 8'h00, image_width: 16'h0000, image_height: 16'h0000
    };

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              fixed;
        result_t           word;
    } file_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pgm_byte_if   byte_bus ();
    pgm_result_if result_bus ();

    pgm_binary_header_parser uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_bus),
        .results (result_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // parser shadow state
    phase_t            ph          = PH_MAGIC;
    line_mode_t        lmode       = LM_START;
    logic              in_number   = 1'b0;
    logic [1:0]        fields_seen = 2'd0;
    logic [1:0]        magic_pos   = 2'd0;
    logic [ACC_W-1:0]  accum       = '0;
    logic [DIM_W-1:0]  width_seen  = '0;
    logic [DIM_W-1:0]  height_seen = '0;
    logic [PIX_W-1:0]  pixels_due  = '0;

    result_t    expected_words [$];
    file_byte_t file_bytes [$];
    file_byte_t opening_rows [16];

    logic       drv_fixed = 1'b0;
    result_t    drv_word  = '0;
    int         mismatch_count = 0;
    int         words_seen = 0;

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 11) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 2);
    endfunction

    task automatic finish_field();
        logic [ACC_W-1:0] v;
        v = accum;
        accum = '0;
        in_number = 1'b0;
        if (fields_seen != 2'd3)
            fields_seen = fields_seen + 2'd1;
        if (v > ACC_MAX)
            ph = PH_ERROR;
        else
        begin
            case (ph)
                PH_WIDTH:
                begin
                    width_seen = v[DIM_W-1:0];
                    ph = PH_HEIGHT;
                end
                PH_HEIGHT:
                begin
                    height_seen = v[DIM_W-1:0];
                    ph = PH_GREY;
                end
                PH_GREY:
                begin
                    if (v != GREY_MAX)
                        ph = PH_ERROR;
                    else
                    begin
                        ph = PH_HDRDONE;
                        lmode = LM_SKIP;
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic close_header();
        pixels_due = PIX_W'(width_seen) * PIX_W'(height_seen);
        ph = (pixels_due != 0) ? PH_PIXELS : PH_DONE;
        lmode = LM_START;
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] c, input logic last,
                              output result_t word);
        status_t           st;
        logic [BYTE_W-1:0] pix;
        logic              consumed;
        logic [31:0]       grown;
        st = ST_HEADER;
        pix = '0;
        consumed = 1'b0;
        if (ph == PH_ERROR)
            st = ST_ERROR;
        else if (ph == PH_DONE)
            st = ST_TRAILING;
        else if (ph == PH_PIXELS)
        begin
            pix = c;
            if (pixels_due <= 1)
            begin
                pixels_due = '0;
                ph = PH_DONE;
                st = ST_LAST_PIXEL;
            end
            else
            begin
                pixels_due = pixels_due - 1;
                st = ST_PIXEL;
            end
        end
        else if (ph == PH_HDRDONE)
        begin
            if (c == CH_LF)
                close_header();
        end
        else
        begin
            if (lmode == LM_START)
            begin
                if (c == CH_LF)
                    consumed = 1'b1;
                else if (c == CH_HASH)
                begin
                    lmode = LM_SKIP;
                    consumed = 1'b1;
                end
                else
                begin
                    lmode = LM_LINE;
                    fields_seen = 2'd0;
                    magic_pos = 2'd0;
                    in_number = 1'b0;
                    accum = '0;
                end
            end
            if (consumed)
                ;
            else if (lmode == LM_SKIP)
            begin
                if (c == CH_LF)
                    lmode = LM_START;
            end
            else if (ph == PH_MAGIC)
            begin
                if (c == CH_LF)
                    ph = PH_ERROR;
                else if (magic_pos == 2'd0)
                begin
                    if (c == CH_P)
                        magic_pos = 2'd1;
                    else if (!is_blank(c))
                        ph = PH_ERROR;
                end
                else if (c == CH_5)
                begin
                    magic_pos = 2'd2;
                    ph = PH_WIDTH;
                    lmode = LM_SKIP;
                end
                else
                    ph = PH_ERROR;
            end
            else if (c == CH_LF)
            begin
                if (in_number)
                    finish_field();
                if (ph == PH_ERROR)
                    ;
                else if (ph == PH_HDRDONE)
                    close_header();
                else if (fields_seen == 2'd0)
                    ph = PH_ERROR;
                else
                begin
                    lmode = LM_START;
                    in_number = 1'b0;
                end
            end
            else if (c >= CH_0 && c <= CH_9)
            begin
                if (!in_number)
                begin
                    accum = ACC_W'(c - CH_0);
                    in_number = 1'b1;
                end
                else
                begin
                    grown = accum * 10 + c - CH_0;
                    accum = (grown > ACC_SAT) ? ACC_SAT : grown[ACC_W-1:0];
                end
            end
            else if (is_blank(c))
            begin
                if (in_number)
                    finish_field();
            end
            else if (in_number)
            begin
                finish_field();
                if (ph != PH_ERROR)
                    lmode = LM_SKIP;
            end
            else if (fields_seen == 2'd0)
                ph = PH_ERROR;
            else
                lmode = LM_SKIP;
        end

        if (ph != PH_ERROR && ph != PH_DONE && last)
            ph = PH_ERROR;
        if (ph == PH_ERROR)
        begin
            st = ST_ERROR;
            pix = '0;
        end
        word.status = st;
        word.pixel = pix;
        word.image_width = width_seen;
        word.image_height = height_seen;
    endtask

    task automatic add_byte(input logic [BYTE_W-1:0] data);
        file_byte_t fb;
        fb = '0;
        fb.data = data;
        file_bytes.push_back(fb);
    endtask

    function automatic logic [BYTE_W-1:0] any_blank();
        case ($urandom_range(0, 4))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0B;
            3: return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    // byte that ends a number without being a blank: signs and NUL favoured
    function automatic logic [BYTE_W-1:0] any_stopper();
        logic [BYTE_W-1:0] c;
        case ($urandom_range(0, 3))
            0: c = "+";
            1: c = "-";
            2: c = 8'h00;
            default:
                do
                    c = 8'($urandom);
                while (is_blank(c) || c == CH_LF || (c >= CH_0 && c <= CH_9));
        endcase
        return c;
    endfunction

    task automatic add_blanks(input int n);
        repeat (n)
            add_byte(any_blank());
    endtask

    task automatic add_junk(input int n);
        logic [BYTE_W-1:0] c;
        repeat (n)
        begin
            do
                c = 8'($urandom);
            while (c == CH_LF);
            add_byte(c);
        end
    endtask

    task automatic add_noise_lines();
        repeat ($urandom_range(0, 2))
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                add_byte(CH_HASH);
                add_junk($urandom_range(0, 12));
            end
            add_byte(CH_LF);
        end
    endtask

    task automatic add_number(input int v);
        string digits;
        digits = $sformatf("%0d", v);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                add_byte(CH_0);
        foreach (digits[i])
            add_byte(digits[i]);
    endtask

    task automatic add_line_end();
        add_blanks($urandom_range(0, 1));
        if ($urandom_range(0, 2) == 0)
        begin
            add_byte(any_stopper());
            add_junk($urandom_range(0, 6));
        end
        add_byte(CH_LF);
    endtask

    // header remainder, pixels and tail; ending 0-3 whole file, 4-5 cut short, 6-7 header fault
    task automatic build_file();
        int dims [3];
        int ending;
        int fault_at;
        int fault_kind;
        int area;
        int cut;
        logic fault_line;
        ending = $urandom_range(0, 7);
        fault_at = $urandom_range(0, 2);
        fault_kind = $urandom_range(0, 4);
        if ($urandom_range(0, 7) == 0)
        begin
            dims[0] = $urandom_range(0, 1) ? 65535 : 0;
            dims[1] = (dims[0] == 0) ? 65535 : 0;
        end
        else
        begin
            dims[0] = $urandom_range(1, 40);
            dims[1] = $urandom_range(1, (900 / dims[0] > 25) ? 25 : 900 / dims[0]);
        end
        dims[2] = 255;
        if (ending >= 6 && fault_kind == 0)
            dims[fault_at] = $urandom_range(65536, 9999999);
        if (ending >= 6 && fault_kind == 1)
        begin
            dims[2] = $urandom_range(0, 65535);
            if (dims[2] == 255)
                dims[2] = 256;
        end

        for (int k = 0; k < 3; k++)
        begin
            fault_line = ending >= 6 && k == fault_at && (fault_kind == 2 || fault_kind == 3);
            if (k == 0 || fault_line || $urandom_range(0, 1) == 1)
            begin
                if (k != 0)
                    add_line_end();
                add_noise_lines();
                if (fault_line && fault_kind == 2)
                begin
                    add_blanks($urandom_range(1, 3));
                    add_byte(CH_LF);
                end
                else if (fault_line)
                begin
                    add_byte(any_blank());
                    add_byte($urandom_range(0, 1) ? CH_HASH : any_stopper());
                    add_junk($urandom_range(0, 5));
                    add_byte(CH_LF);
                end
                add_blanks($urandom_range(0, 2));
            end
            else
                add_blanks($urandom_range(1, 3));
            add_number(dims[k]);
        end
        add_line_end();
        if (ending >= 6 && fault_kind == 4)
            file_bytes[$].last = 1'b1;

        if (ending < 6)
        begin
            area = dims[0] * dims[1];
            cut = (ending >= 4 && area > 0) ? $urandom_range(0, area - 1) : area;
            for (int p = 0; p < area && p <= cut; p++)
            begin
                add_byte(8'($urandom));
                if (p == cut || (p == area - 1 && $urandom_range(0, 1) == 1))
                    file_bytes[$].last = 1'b1;
            end
        end

        while (file_bytes.size() < ITEM_TOTAL)
        begin
            add_byte(8'($urandom));
            file_bytes[$].last = ($urandom_range(0, 3) == 0);
        end
    endtask

    // source side
    initial
    begin
        int  gap;
        logic src_steady;
        src_steady = 1'b0;
        byte_bus.valid = 1'b0;
        byte_bus.data_byte = '0;
        byte_bus.last_byte = 1'b0;

        // comments, empty lines, blanks before the magic, junk after it
        opening_rows = '{
            '{CH_LF,   1'b0, 1'b1, HEADER_QUIET},
            '{CH_HASH, 1'b0, 1'b1, HEADER_QUIET},
            '{8'hFF,   1'b0, 1'b1, HEADER_QUIET},
            '{8'h00,   1'b0, 1'b1, HEADER_QUIET},
            '{CH_LF,   1'b0, 1'b1, HEADER_QUIET},
            '{8'h0D,   1'b0, 1'b1, HEADER_QUIET},
            '{8'h09,   1'b0, 1'b1, HEADER_QUIET},
            '{CH_P,    1'b0, 1'b1, HEADER_QUIET},
            '{CH_5,    1'b0, 1'b1, HEADER_QUIET},
            '{"-",     1'b0, 1'b1, HEADER_QUIET},
            '{CH_HASH, 1'b0, 1'b1, HEADER_QUIET},
            '{CH_LF,   1'b0, 1'b1, HEADER_QUIET},
            '{CH_HASH, 1'b0, 1'b1, HEADER_QUIET},
            '{8'h80,   1'b0, 1'b1, HEADER_QUIET},
            '{CH_LF,   1'b0, 1'b1, HEADER_QUIET},
            '{CH_LF,   1'b0, 1'b1, HEADER_QUIET}
        };
        foreach (opening_rows[i])
            file_bytes.push_back(opening_rows[i]);
        build_file();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < file_bytes.size(); i++)
        begin
            gap = src_steady ? 0 : pick_gap();
            if (gap != 0)
            begin
                byte_bus.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            byte_bus.valid = 1'b1;
            byte_bus.data_byte = file_bytes[i].data;
            byte_bus.last_byte = file_bytes[i].last;
            drv_fixed = file_bytes[i].fixed;
            drv_word = file_bytes[i].word;
            @(posedge clk);
            while (!byte_bus.ready)
                @(posedge clk);
            @(negedge clk);
            if ($urandom_range(0, 49) == 0)
                src_steady = !src_steady;
        end
        byte_bus.valid = 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // sink side
    initial
    begin
        int   hold;
        logic sink_steady;
        hold = 0;
        sink_steady = 1'b0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 59) == 0)
                sink_steady = !sink_steady;
            if (sink_steady)
                result_bus.ready = 1'b1;
            else if (hold != 0)
            begin
                hold = hold - 1;
                result_bus.ready = 1'b0;
            end
            else
            begin
                result_bus.ready = 1'b1;
                if ($urandom_range(0, 2) == 0)
                    hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_words
        result_t predicted;
        result_t seen;
        result_t wanted;
        if (rst_n)
        begin
            if (byte_bus.valid && byte_bus.ready)
            begin
                parse_byte(byte_bus.data_byte, byte_bus.last_byte, predicted);
                expected_words.push_back(drv_fixed ? drv_word : predicted);
            end
            if (result_bus.valid && result_bus.ready)
            begin
                seen.status = status_t'(result_bus.status);
                seen.pixel = result_bus.pixel;
                seen.image_width = result_bus.image_width;
                seen.image_height = result_bus.image_height;
                if (expected_words.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("word %0d: unexpected, status %0d", words_seen, seen.status);
                    mismatch_count++;
                end
                else
                begin
                    wanted = expected_words.pop_front();
                    if (seen.status !== wanted.status || seen.pixel !== wanted.pixel
                        || seen.image_width !== wanted.image_width
                        || seen.image_height !== wanted.image_height)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("word %0d (exp/got): status %0d/%0d pixel %02h/%02h",
                                     words_seen, wanted.status, seen.status,
                                     wanted.pixel, seen.pixel);
                            $display("    width %0d/%0d height %0d/%0d",
                                     wanted.image_width, seen.image_width,
                                     wanted.image_height, seen.image_height);
                        end
                        mismatch_count++;
                    end
                end
                words_seen++;
            end
        end
    end

    // hard limit on run length
    initial
    begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
